### src/kct_pkg.sv
// ----------------------------------------------------------------------------
// kct_pkg
// Shared sizes, codes and types of the keyed counter table.
// ----------------------------------------------------------------------------
package kct_pkg;

	localparam int ENTRIES = 16;
	localparam int KEY_W   = 15;
	localparam int CNT_W   = 8;
	localparam int TOTAL_W = 12;

	typedef enum logic [1:0] {
		ST_UPDATED   = 2'd0,
		ST_ALLOCATED = 2'd1,
		ST_FULL      = 2'd2,
		ST_CLEARED   = 2'd3
	} status_t;

	typedef enum logic {
		KIND_ADD   = 1'b0,
		KIND_CLEAR = 1'b1
	} kind_t;

	// Result of one table search: one-hot hit, one-hot free-entry grant and
	// the count held by the hit entry (zero when there is no hit).
	typedef struct packed {
		logic [ENTRIES-1:0] hit;
		logic [ENTRIES-1:0] grant;
		logic [CNT_W-1:0]   old_count;
	} lookup_t;

endpackage

### src/kct_lookup.sv
// ----------------------------------------------------------------------------
// kct_lookup
// Parallel key compare and lowest-free-entry pick over the whole table.
// ----------------------------------------------------------------------------
module kct_lookup (
	input  logic [kct_pkg::KEY_W-1:0]   key,
	input  logic [kct_pkg::ENTRIES-1:0] entry_valid,
	input  logic [kct_pkg::KEY_W-1:0]   entry_key   [kct_pkg::ENTRIES],
	input  logic [kct_pkg::CNT_W-1:0]   entry_count [kct_pkg::ENTRIES],
	output kct_pkg::lookup_t            result
);
	import kct_pkg::*;

	logic [ENTRIES-1:0] free_vec;
	logic [ENTRIES-1:0] hit_vec;
	logic [CNT_W-1:0]   old_count;

	// Keys of valid entries are unique, so at most one hit bit is set.
	always_comb begin
		hit_vec   = '0;
		old_count = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			hit_vec[i] = entry_valid[i] && (entry_key[i] == key);
			old_count  = old_count | (entry_count[i] & {CNT_W{hit_vec[i]}});
		end
	end

	// Isolate the lowest set bit of the free vector.
	assign free_vec = ~entry_valid;

	assign result.hit       = hit_vec;
	assign result.grant     = free_vec & (~free_vec + ENTRIES'(1));
	assign result.old_count = old_count;

endmodule

### src/keyed_counter_table.sv
// ----------------------------------------------------------------------------
// keyed_counter_table
// Associative table of per-key 8-bit counters with a running total.
// ----------------------------------------------------------------------------
// A result strobes on done once its item has passed the input register and
// the result register. Throughput: one item per cycle; busy is never raised,
// because the search, the update of the table and the total all settle
// between the input register and the result register.
// Reset: arst_n empties every entry, zeroes the total and drops done.
// The receiver cannot stall, so no result is ever held back.
module keyed_counter_table (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic                        kind,
	input  logic [kct_pkg::KEY_W-1:0]   key,
	input  logic [kct_pkg::CNT_W-1:0]   increment,
	output logic                        done,
	output logic [kct_pkg::CNT_W-1:0]   count,
	output logic [1:0]                  status,
	output logic [kct_pkg::TOTAL_W-1:0] total
);
	import kct_pkg::*;

	localparam int PAD_W = TOTAL_W - CNT_W;

	// Input register: the accepted item.
	logic               valid_s1;
	kind_t              kind_s1;
	logic [KEY_W-1:0]   key_s1;
	logic [CNT_W-1:0]   inc_s1;

	// Table state. Keys and counts are only read while their entry is valid,
	// so they carry no reset.
	logic [ENTRIES-1:0] valid_q;
	logic [KEY_W-1:0]   key_q   [ENTRIES];
	logic [CNT_W-1:0]   count_q [ENTRIES];
	logic [TOTAL_W-1:0] total_q;

	// Result register.
	logic               done_s2;
	logic [CNT_W-1:0]   count_s2;
	status_t            status_s2;
	logic [TOTAL_W-1:0] total_s2;

	lookup_t            look;
	logic               is_hit;
	logic               has_free;
	logic [CNT_W-1:0]   new_count;
	logic [CNT_W-1:0]   res_count;
	status_t            res_status;
	logic [TOTAL_W-1:0] next_total;

	// Nothing in the datapath ever needs to hold an item back.
	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			kind_s1 <= kind_t'(kind);
			key_s1  <= key;
			inc_s1  <= increment;
		end
	end

	kct_lookup u_lookup (
		.key         (key_s1),
		.entry_valid (valid_q),
		.entry_key   (key_q),
		.entry_count (count_q),
		.result      (look)
	);

	assign is_hit    = |look.hit;
	assign has_free  = |look.grant;
	assign new_count = look.old_count + inc_s1;

	// Decide the outcome of the item in the input register. The total is
	// updated incrementally: a hit swaps the old count for the new one, an
	// allocation adds the increment. With no hit and no free entry the item
	// reports a full table and the total stays as it is; a clear zeroes it.
	always_comb begin
		res_count  = '0;
		res_status = ST_FULL;
		next_total = total_q;
		priority if (kind_s1 == KIND_CLEAR) begin
			res_status = ST_CLEARED;
			next_total = '0;
		end else if (is_hit) begin
			res_count  = new_count;
			res_status = ST_UPDATED;
			next_total = total_q - {{PAD_W{1'b0}}, look.old_count}
			             + {{PAD_W{1'b0}}, new_count};
		end else if (has_free) begin
			res_count  = inc_s1;
			res_status = ST_ALLOCATED;
			next_total = total_q + {{PAD_W{1'b0}}, inc_s1};
		end else begin
			res_status = ST_FULL;
		end
	end

	// Valid bits and the running total: a clear empties the whole table at once.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			total_q <= '0;
		end else if (valid_s1) begin
			total_q <= next_total;
			if (kind_s1 == KIND_CLEAR) begin
				valid_q <= '0;
			end else if (!is_hit) begin
				valid_q <= valid_q | look.grant;
			end
		end
	end

	// Entry payload: the hit entry takes its new count, or the granted free
	// entry takes the key and the increment.
	always_ff @(posedge clk) begin
		if (valid_s1 && kind_s1 == KIND_ADD) begin
			for (int i = 0; i < ENTRIES; i++) begin
				if (look.hit[i]) begin
					count_q[i] <= new_count;
				end else if (!is_hit && look.grant[i]) begin
					key_q[i]   <= key_s1;
					count_q[i] <= inc_s1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s2 <= 1'b0;
		end else begin
			done_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			count_s2  <= res_count;
			status_s2 <= res_status;
			total_s2  <= next_total;
		end
	end

	assign done   = done_s2;
	assign count  = count_s2;
	assign status = status_s2;
	assign total  = total_s2;

endmodule
